[hdl/pprh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel predictor residual histogram package
// Shared widths, codes, structures and the residual folding function.
// ----------------------------------------------------------------------------
package pprh_pkg;

  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned RES_W    = 9;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PRED_W   = 2;
  localparam int unsigned NUM_BINS = 512;
  localparam int unsigned BIN_W    = $clog2(NUM_BINS);

  localparam int unsigned MAX_WIDTH_DEFAULT      = 4096;
  localparam int unsigned NUM_PREDICTORS_DEFAULT = 3;

  localparam logic [CFG_W-1:0]   IMAGE_WIDTH_RESET = 13'd640;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
  localparam logic [BIN_W-1:0]   LAST_BIN          = BIN_W'(NUM_BINS - 1);

  // Result queue between the pipeline and the output port.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [MODE_W-1:0] {
    MODE_PIXEL   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_INC,
    HOP_READ_CLEAR
  } hist_op_e;

  typedef struct packed {
    hist_op_e         op;
    logic [BIN_W-1:0] addr;
  } hist_req_t;

  typedef struct packed {
    logic             active;
    logic [BIN_W-1:0] addr;
  } hist_clr_t;

  typedef struct packed {
    logic signed [RES_W-1:0] res_left;
    logic signed [RES_W-1:0] res_up;
    logic signed [RES_W-1:0] res_diag;
    logic [COUNT_W-1:0]      count;
  } result_t;

  // Maps e >= 0 to 2e and e < 0 to -2e-1.
  function automatic logic [BIN_W-1:0] fold_residual(input logic signed [RES_W-1:0] e);
    logic [BIN_W-1:0] twice;
    twice = {e[BIN_W-2:0], 1'b0};
    return e[RES_W-1] ? ~twice : twice;
  endfunction

endpackage

[hdl/pprh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data returning old contents.
// ----------------------------------------------------------------------------
module pprh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pprh_hist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Residual histogram bank
// One 512-bin counter memory with read-modify-write, write-to-read forwarding
// and a shared clearing pass.
// ----------------------------------------------------------------------------
module pprh_hist (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pprh_pkg::hist_req_t         req_i,
  input  pprh_pkg::hist_clr_t         clr_i,
  output logic [pprh_pkg::COUNT_W-1:0] count_o
);

  import pprh_pkg::*;

  hist_op_e           op_q;
  logic [BIN_W-1:0]   addr_q;
  logic [COUNT_W-1:0] rdata;
  logic               fwd_valid_q;
  logic [BIN_W-1:0]   fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic [COUNT_W-1:0] cur;
  logic               we;
  logic [BIN_W-1:0]   waddr;
  logic [COUNT_W-1:0] wdata;

  pprh_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(NUM_BINS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(req_i.addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= HOP_NONE;
      fwd_valid_q <= 1'b0;
    end else begin
      op_q        <= req_i.op;
      fwd_valid_q <= we;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= req_i.addr;
    fwd_addr_q <= waddr;
    fwd_data_q <= wdata;
  end

  // The RAM returns old data when the previous word wrote the same bin.
  assign cur = (fwd_valid_q && (fwd_addr_q == addr_q)) ? fwd_data_q : rdata;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = cur;
    if (clr_i.active) begin
      we    = 1'b1;
      waddr = clr_i.addr;
      wdata = '0;
    end else begin
      case (op_q)
        HOP_INC: begin
          we    = 1'b1;
          wdata = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
        end
        HOP_READ_CLEAR: begin
          we    = 1'b1;
          wdata = '0;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  assign count_o = cur;

endmodule

[hdl/pixel_predictor_residual_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel predictor residual histogram
// Left, up and diagonal residuals of a grey raster stream with histograms.
// ----------------------------------------------------------------------------
// Usage: words enter on the in channel (mode, pixel, read_predictor, read_bin)
// and every word yields exactly one word on the out channel, in order. Mode 0
// carries a pixel in raster order and returns its three residuals; mode 1
// returns one histogram bin and clears it; mode 2 restarts the raster
// position; mode 3 returns zeros. The cfg channel writes image_width and is
// always ready; write it only while no word is in flight.
// Flow: an accepted word passes the residual and histogram stages into the
// result queue. Throughput: one word per cycle while in_ready_o is high, set
// by the single read-modify-write per histogram memory per cycle (read in one
// cycle, written in the next, with forwarding between neighbouring words).
// Reset: the counter memories are swept to zero, one bin of all three
// histograms per cycle, and in_ready_o stays low until every bin is cleared.
// Stalls: a four-word result queue follows the pipeline; in_ready_o drops
// once four words are accepted but not yet delivered, so a stalled receiver
// holds the input back without losing any result.
// ----------------------------------------------------------------------------
module pixel_predictor_residual_histogram #(
  parameter int unsigned MAX_WIDTH      = pprh_pkg::MAX_WIDTH_DEFAULT,
  parameter int unsigned NUM_PREDICTORS = pprh_pkg::NUM_PREDICTORS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input words
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pprh_pkg::MODE_W-1:0]        mode_i,
  input  logic [pprh_pkg::PIXEL_W-1:0]       pixel_i,
  input  logic [pprh_pkg::PRED_W-1:0]        read_predictor_i,
  input  logic [pprh_pkg::BIN_W-1:0]         read_bin_i,
  // Result words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pprh_pkg::RES_W-1:0]  residual_left_o,
  output logic signed [pprh_pkg::RES_W-1:0]  residual_up_o,
  output logic signed [pprh_pkg::RES_W-1:0]  residual_diag_o,
  output logic [pprh_pkg::COUNT_W-1:0]       bin_count_o,
  // Configuration write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pprh_pkg::CFG_W-1:0]         cfg_image_width_i
);

  import pprh_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  // Configuration
  logic [CFG_W-1:0] image_width_q;

  // Acceptance stage: raster position
  logic             accept;
  logic [COL_W-1:0] column_q;
  logic             first_row_q;
  logic [COL_W:0]   col_next;
  logic             row_wrap;
  logic             row_we;
  logic [PIXEL_W-1:0] row_rdata;

  // Residual stage
  logic               s1_valid_q;
  logic [MODE_W-1:0]  s1_mode_q;
  logic [PIXEL_W-1:0] s1_pixel_q;
  logic [PRED_W-1:0]  s1_rpred_q;
  logic [BIN_W-1:0]   s1_rbin_q;
  logic               s1_col0_q;
  logic               s1_first_q;
  logic [PIXEL_W-1:0] left_q;
  logic [PIXEL_W-1:0] upper_left_q;
  logic [PIXEL_W-1:0] nb_left;
  logic [PIXEL_W-1:0] nb_up;
  logic [PIXEL_W-1:0] nb_diag;
  logic signed [RES_W-1:0] res_left;
  logic signed [RES_W-1:0] res_up;
  logic signed [RES_W-1:0] res_diag;
  logic               s1_is_pixel;

  // Histogram stage
  logic                    s2_valid_q;
  logic [MODE_W-1:0]       s2_mode_q;
  logic [PRED_W-1:0]       s2_rpred_q;
  logic signed [RES_W-1:0] s2_res_left_q;
  logic signed [RES_W-1:0] s2_res_up_q;
  logic signed [RES_W-1:0] s2_res_diag_q;
  hist_req_t               hist_req [NUM_PREDICTORS];
  logic [COUNT_W-1:0]      hist_count [NUM_PREDICTORS];
  logic [COUNT_W-1:0]      sel_count;
  result_t                 s2_result;

  // Clearing pass
  logic       clearing_q;
  logic [BIN_W-1:0] clr_addr_q;
  hist_clr_t  clr;

  // Result queue
  result_t           queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   queued_q;
  logic [QPTR_W:0]   inflight_q;
  logic              pop;

  // --------------------------------------------------------------------------
  // Configuration register; writes are always taken.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      image_width_q <= cfg_image_width_i;
    end
  end

  // --------------------------------------------------------------------------
  // Acceptance. A word is taken when the clearing pass is over and the queue
  // has room for every word already in the pipeline.
  // --------------------------------------------------------------------------
  assign in_ready_o = !clearing_q && (inflight_q < (QPTR_W + 1)'(QUEUE_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  // The row ends when the next column reaches the width. A width of zero
  // therefore ends every row at once, and widths beyond the line store
  // are capped by its depth.
  assign col_next = {1'b0, column_q} + (COL_W + 1)'(1);
  assign row_wrap = (col_next >= (COL_W + 1)'(MAX_WIDTH)) ||
                    (CMP_W'(col_next) >= CMP_W'(image_width_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      first_row_q <= 1'b1;
    end else if (accept) begin
      case (mode_i)
        MODE_PIXEL: begin
          if (row_wrap) begin
            column_q    <= '0;
            first_row_q <= 1'b0;
          end else begin
            column_q <= col_next[COL_W-1:0];
          end
        end
        MODE_RESTART: begin
          column_q    <= '0;
          first_row_q <= 1'b1;
        end
        default: begin
          column_q <= column_q;
        end
      endcase
    end
  end

  // The line store is read and written at the same column in the same
  // cycle; the read returns the pixel of the previous row.
  assign row_we = accept && (mode_i == MODE_PIXEL);

  pprh_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(column_q),
    .wdata_i(pixel_i),
    .raddr_i(column_q),
    .rdata_o(row_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q  <= mode_i;
    s1_pixel_q <= pixel_i;
    s1_rpred_q <= read_predictor_i;
    s1_rbin_q  <= read_bin_i;
    s1_col0_q  <= (column_q == '0);
    s1_first_q <= first_row_q;
  end

  // --------------------------------------------------------------------------
  // Residuals. Neighbours outside the image are taken as zero.
  // --------------------------------------------------------------------------
  assign s1_is_pixel = (s1_mode_q == MODE_PIXEL);
  assign nb_left     = s1_col0_q ? '0 : left_q;
  assign nb_up       = s1_first_q ? '0 : row_rdata;
  assign nb_diag     = (s1_col0_q || s1_first_q) ? '0 : upper_left_q;

  assign res_left = s1_is_pixel ? $signed({1'b0, s1_pixel_q}) - $signed({1'b0, nb_left}) : '0;
  assign res_up   = s1_is_pixel ? $signed({1'b0, s1_pixel_q}) - $signed({1'b0, nb_up})   : '0;
  assign res_diag = s1_is_pixel ? $signed({1'b0, s1_pixel_q}) - $signed({1'b0, nb_diag}) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      upper_left_q <= '0;
    end else if (s1_valid_q) begin
      case (s1_mode_q)
        MODE_PIXEL: begin
          left_q       <= s1_pixel_q;
          upper_left_q <= nb_up;
        end
        MODE_RESTART: begin
          left_q       <= '0;
          upper_left_q <= '0;
        end
        default: begin
          left_q <= left_q;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Histogram requests: a pixel bumps one bin in every histogram, a read
  // fetches and clears one bin of the chosen histogram.
  // --------------------------------------------------------------------------
  assign clr.active = clearing_q;
  assign clr.addr   = clr_addr_q;

  for (genvar p = 0; p < NUM_PREDICTORS; p++) begin : g_hist
    logic signed [RES_W-1:0] res_p;

    assign res_p = (p == 0) ? res_left : ((p == 1) ? res_up : res_diag);

    always_comb begin
      hist_req[p].op   = HOP_NONE;
      hist_req[p].addr = s1_rbin_q;
      if (s1_valid_q) begin
        case (s1_mode_q)
          MODE_PIXEL: begin
            hist_req[p].op   = HOP_INC;
            hist_req[p].addr = fold_residual(res_p);
          end
          MODE_READ: begin
            if (s1_rpred_q == PRED_W'(p)) begin
              hist_req[p].op = HOP_READ_CLEAR;
            end
          end
          default: begin
            hist_req[p].op = HOP_NONE;
          end
        endcase
      end
    end

    pprh_hist u_hist (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (hist_req[p]),
      .clr_i  (clr),
      .count_o(hist_count[p])
    );
  end

  // Clearing pass after reset, one bin of every histogram per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + BIN_W'(1);
      if (clr_addr_q == LAST_BIN) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q     <= s1_mode_q;
    s2_rpred_q    <= s1_rpred_q;
    s2_res_left_q <= res_left;
    s2_res_up_q   <= res_up;
    s2_res_diag_q <= res_diag;
  end

  // An unknown predictor selects nothing and reads as zero.
  always_comb begin
    sel_count = '0;
    if (s2_mode_q == MODE_READ) begin
      for (int p = 0; p < NUM_PREDICTORS; p++) begin
        if (s2_rpred_q == PRED_W'(p)) begin
          sel_count = hist_count[p];
        end
      end
    end
  end

  assign s2_result.res_left = s2_res_left_q;
  assign s2_result.res_up   = s2_res_up_q;
  assign s2_result.res_diag = s2_res_diag_q;
  assign s2_result.count    = sel_count;

  // --------------------------------------------------------------------------
  // Result queue and in-flight count.
  // --------------------------------------------------------------------------
  assign out_valid_o = (queued_q != '0);
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      queue_q[wr_ptr_q] <= s2_result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      queued_q   <= '0;
      inflight_q <= '0;
    end else begin
      if (s2_valid_q) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      queued_q   <= queued_q + (QPTR_W + 1)'(s2_valid_q) - (QPTR_W + 1)'(pop);
      inflight_q <= inflight_q + (QPTR_W + 1)'(accept) - (QPTR_W + 1)'(pop);
    end
  end

  assign residual_left_o = queue_q[rd_ptr_q].res_left;
  assign residual_up_o   = queue_q[rd_ptr_q].res_up;
  assign residual_diag_o = queue_q[rd_ptr_q].res_diag;
  assign bin_count_o     = queue_q[rd_ptr_q].count;

endmodule

[hdl/pprh_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel predictor residual histogram checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module pprh_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic signed [8:0] residual_left_o,
  input logic signed [8:0] residual_up_o,
  input logic signed [8:0] residual_diag_o,
  input logic [31:0]       bin_count_o
);

  logic [3:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Words accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  // No result without a word to answer.
  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 4'd0))
    else $error("result offered with no word outstanding");

  // The block never takes more words than its result queue can hold.
  a_credit_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (pending_q < 4'd4))
    else $error("input ready beyond the result queue depth");

  // The histogram clearing pass holds the input back after reset.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_o)
    else $error("input ready during the clearing pass");

  // A result carries either residuals or a bin count, never both.
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((bin_count_o == 32'd0) ||
                     ((residual_left_o == 9'sd0) && (residual_up_o == 9'sd0) &&
                      (residual_diag_o == 9'sd0))))
    else $error("result mixes residuals and a bin count");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(bin_count_o) &&
                                       $stable(residual_left_o)))
    else $error("stalled result changed");

endmodule

bind pixel_predictor_residual_histogram pprh_checker u_pprh_checker (.*);

[tb/sv/tb_pixel_predictor_residual_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the pixel predictor residual histogram
// Streams grey pixels, bin reads, restarts and unused-mode words through the
// block under several image widths and idle patterns. Every result word is
// compared field by field with an in-order prediction of the residuals and
// of the three residual histograms.
// ----------------------------------------------------------------------------
module tb_pixel_predictor_residual_histogram;

  import pprh_pkg::*;

  localparam int unsigned MAX_W       = MAX_WIDTH_DEFAULT;
  localparam int unsigned NUM_PRED    = NUM_PREDICTORS_DEFAULT;
  localparam int unsigned STALL_LIMIT = 4000;  // covers the clearing sweep after reset
  localparam int unsigned SETTLE      = 4;     // cycles of quiet before a width write
  localparam int unsigned MAX_SHOWN   = 20;

  // Mode 3 has no name in the package; the block must answer it with zeros.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Histogram selectors for mode 1 reads.
  localparam logic [PRED_W-1:0] PRED_LEFT = 2'd0;
  localparam logic [PRED_W-1:0] PRED_UP   = 2'd1;
  localparam logic [PRED_W-1:0] PRED_DIAG = 2'd2;
  localparam logic [PRED_W-1:0] PRED_NONE = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: it carries its own copy of the raster state and histograms,
  // works out the result of every accepted word and holds it until the block
  // delivers the matching result word.
  // --------------------------------------------------------------------------
  class residual_scoreboard;
    logic [PIXEL_W-1:0] row_store [MAX_W];
    bit                 row_written [MAX_W];
    logic [PIXEL_W-1:0] left_px;
    logic [PIXEL_W-1:0] upleft_px;
    int unsigned        column;
    bit                 first_row;
    logic [COUNT_W-1:0] counts [NUM_PRED][NUM_BINS];
    logic [CFG_W-1:0]   image_width;
    result_t            expected [$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        words_by_mode [4];

    function new();
      left_px      = '0;
      upleft_px    = '0;
      column       = 0;
      first_row    = 1'b1;
      image_width  = IMAGE_WIDTH_RESET;
      mismatches   = 0;
      results_seen = 0;
      foreach (counts[p, b]) counts[p][b] = '0;
      foreach (row_written[i]) row_written[i] = 1'b0;
      foreach (words_by_mode[i]) words_by_mode[i] = 0;
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
    endtask

    function void note_word(input logic [MODE_W-1:0] mode, input logic [PIXEL_W-1:0] px,
                            input logic [PRED_W-1:0] pred, input logic [BIN_W-1:0] bin);
      result_t     r;
      int unsigned w;
      int          nbr [3];
      int          e;
      int          slot;
      r = '0;
      words_by_mode[mode]++;
      case (mode)
        MODE_PIXEL: begin
          w = 32'(image_width);
          if (w == 0) begin
            w = 1;
          end else if (w > MAX_W) begin
            w = MAX_W;
          end
          // Neighbours outside the image count as zero.
          nbr[0] = (column == 0) ? 0 : int'(left_px);
          nbr[1] = first_row ? 0 : int'(row_store[column]);
          nbr[2] = (column == 0 || first_row) ? 0 : int'(upleft_px);
          for (int k = 0; k < 3; k++) begin
            e = int'(px) - nbr[k];
            case (k)
              0:       r.res_left = RES_W'(e);
              1:       r.res_up   = RES_W'(e);
              default: r.res_diag = RES_W'(e);
            endcase
            slot = (e >= 0) ? 2 * e : -2 * e - 1;
            if (counts[k][slot] != COUNT_MAX) begin
              counts[k][slot] = counts[k][slot] + COUNT_W'(1);
            end
          end
          upleft_px           = PIXEL_W'(nbr[1]);
          left_px             = px;
          row_store[column]   = px;
          row_written[column] = 1'b1;
          column++;
          if (column >= w) begin
            column    = 0;
            first_row = 1'b0;
          end
        end
        MODE_READ: begin
          if (32'(pred) < NUM_PRED) begin
            r.count           = counts[pred][bin];
            counts[pred][bin] = '0;
          end
        end
        MODE_RESTART: begin
          column    = 0;
          first_row = 1'b1;
          left_px   = '0;
          upleft_px = '0;
        end
        default: ;
      endcase
      expected.push_back(r);
    endfunction

    task check_word(input result_t seen);
      result_t want;
      results_seen++;
      if (expected.size() == 0) begin
        report("result word with no word outstanding");
        return;
      end
      want = expected.pop_front();
      if (seen.res_left !== want.res_left)
        report($sformatf("residual_left %0d, expected %0d", seen.res_left, want.res_left));
      if (seen.res_up !== want.res_up)
        report($sformatf("residual_up %0d, expected %0d", seen.res_up, want.res_up));
      if (seen.res_diag !== want.res_diag)
        report($sformatf("residual_diag %0d, expected %0d", seen.res_diag, want.res_diag));
      if (seen.count !== want.count)
        report($sformatf("bin_count %0d, expected %0d", seen.count, want.count));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts from a known value.
  // --------------------------------------------------------------------------
  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                in_valid_i        = 1'b0;
  logic                in_ready_o;
  logic [MODE_W-1:0]   mode_i            = '0;
  logic [PIXEL_W-1:0]  pixel_i           = '0;
  logic [PRED_W-1:0]   read_predictor_i  = '0;
  logic [BIN_W-1:0]    read_bin_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i       = 1'b0;
  logic signed [RES_W-1:0] residual_left_o;
  logic signed [RES_W-1:0] residual_up_o;
  logic signed [RES_W-1:0] residual_diag_o;
  logic [COUNT_W-1:0]  bin_count_o;
  logic                cfg_valid_i       = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    cfg_image_width_i = '0;

  residual_scoreboard sb;

  // Idle pattern of the current phase, in cycles per hundred.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned width_writes = 0;
  int unsigned quiet_cycles = 0;
  logic [PIXEL_W-1:0] walk_px = '0;

  pixel_predictor_residual_histogram DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .pixel_i          (pixel_i),
    .read_predictor_i (read_predictor_i),
    .read_bin_i       (read_bin_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .residual_left_o  (residual_left_o),
    .residual_up_o    (residual_up_o),
    .residual_diag_o  (residual_diag_o),
    .bin_count_o      (bin_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_image_width_i(cfg_image_width_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The receiver decides afresh at every falling edge whether to take a word.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: all handshakes are sampled at the rising edge, before the block
  // updates its outputs. The result is checked before the new word is noted,
  // although a word can never return in the cycle it is accepted. The
  // watchdog ends the run if nothing at all moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.res_left  = residual_left_o;
        seen.res_up    = residual_up_o;
        seen.res_diag  = residual_diag_o;
        seen.count     = bin_count_o;
        sb.check_word(seen);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_word(mode_i, pixel_i, read_predictor_i, read_bin_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.image_width = cfg_image_width_i;
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. They are entered and left just after a falling edge. Valid is
  // left high after an accepted word so that back-to-back words flow without
  // a gap; it is only lowered for an idle cycle or a drain.
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [MODE_W-1:0] mode, input logic [PIXEL_W-1:0] px,
                           input logic [PRED_W-1:0] pred, input logic [BIN_W-1:0] bin);
    // A pixel whose upper neighbour was never written (the row has grown past
    // anything stored) would read undefined memory, so a restart goes instead.
    if (mode == MODE_PIXEL && !sb.first_row && !sb.row_written[sb.column]) begin
      mode = MODE_RESTART;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    mode_i           = mode;
    pixel_i          = px;
    read_predictor_i = pred;
    read_bin_i       = bin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Holds the input back until every outstanding word has come back.
  task automatic drain();
    in_valid_i = 1'b0;
    do @(negedge clk_i); while (sb.expected.size() != 0);
  endtask

  // The width is only changed while the block is empty.
  task automatic write_width(input logic [CFG_W-1:0] width);
    drain();
    repeat (SETTLE) @(negedge clk_i);
    cfg_valid_i       = 1'b1;
    cfg_image_width_i = width;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    width_writes++;
  endtask

  // One random phase: a width, an idle pattern and a run of mixed words.
  // Most words are pixels, half of them a slow random walk so that the
  // residuals stay small and the low bins fill, then bin reads that lean
  // towards those low bins, and a few restarts and unused-mode words.
  task automatic run_phase(input logic [CFG_W-1:0] width, input int unsigned style,
                           input int unsigned n_words);
    logic [MODE_W-1:0]  mode;
    logic [PIXEL_W-1:0] px;
    logic [PRED_W-1:0]  pred;
    logic [BIN_W-1:0]   bin;
    int unsigned        pick;
    int                 level;
    write_width(width);
    send_idle_pct  = (style == 1) ? 57 : (style == 3) ? 29 : 0;
    recv_stall_pct = (style == 2) ? 57 : (style == 3) ? 29 : 0;
    for (int unsigned n = 0; n < n_words; n++) begin
      // Halfway through, the sender waits for every result to come back.
      if (n == n_words / 2) begin
        drain();
      end
      pick = $urandom_range(99);
      px   = PIXEL_W'($urandom);
      pred = PRED_W'($urandom);
      bin  = BIN_W'($urandom);
      if (pick < 72) begin
        mode = MODE_PIXEL;
        if ($urandom_range(1) == 1) begin
          level = int'(walk_px) + int'($urandom_range(12)) - 6;
          if (level < 0) level = 0;
          if (level > 255) level = 255;
          px = PIXEL_W'(level);
        end
        walk_px = px;
      end else if (pick < 90) begin
        mode = MODE_READ;
        if ($urandom_range(9) != 0) pred = PRED_W'($urandom_range(PRED_DIAG));
        if ($urandom_range(9) < 6) bin = BIN_W'($urandom_range(20));
      end else if (pick < 95) begin
        mode = MODE_RESTART;
      end else begin
        mode = MODE_UNUSED;
      end
      push_word(mode, px, pred, bin);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] widths [8];
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, with no idling. Rows of three pixels first: extreme
    // values give the largest positive residuals on all three predictors and
    // the largest negative ones on left and up; bins near the top are then read back.
    write_width(13'd3);
    push_word(MODE_RESTART, '1, PRED_NONE, '1);
    push_word(MODE_PIXEL, 8'd0,   PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd255, PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd0,   PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd255, PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd0,   PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd255, PRED_LEFT, '0);
    push_word(MODE_READ, '0, PRED_UP,   9'd510);
    push_word(MODE_READ, '0, PRED_DIAG, 9'd509);
    // The top bin can never be reached by a residual.
    push_word(MODE_READ, '0, PRED_LEFT, LAST_BIN);
    // A read of a histogram that does not exist gives zero and clears nothing.
    push_word(MODE_READ, '0, PRED_NONE, 9'd0);
    // Reading a bin a second time shows that the first read cleared it.
    push_word(MODE_READ, '0, PRED_UP,   9'd510);
    push_word(MODE_UNUSED, '1, PRED_NONE, '1);

    // A row of six and part of the next, then the width shrinks below the
    // current column, so the row must end after the very next pixel.
    write_width(13'd6);
    push_word(MODE_RESTART, '0, PRED_LEFT, '0);
    for (int k = 0; k < 10; k++) begin
      push_word(MODE_PIXEL, PIXEL_W'(k * 27), PRED_LEFT, '0);
    end
    write_width(13'd2);
    push_word(MODE_PIXEL, 8'd200, PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd3,   PRED_LEFT, '0);
    push_word(MODE_PIXEL, 8'd90,  PRED_LEFT, '0);

    // Random part: zero acts as one and anything above the line buffer size
    // acts as its size, so both extremes and the all-ones value appear. The
    // idle pattern steps through all four styles across the phases.
    widths[0] = 13'd1;
    widths[1] = 13'd0;
    widths[2] = 13'd5;
    widths[3] = 13'd4096;
    widths[4] = 13'd8191;
    widths[5] = 13'd12;
    widths[6] = CFG_W'($urandom_range(64, 2));
    widths[7] = CFG_W'($urandom_range(8191, 65));
    for (int unsigned ph = 0; ph < 8; ph++) begin
      run_phase(widths[ph], ph % 4, 94);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.expected.size() != 0) begin
      sb.report($sformatf("%0d result words never arrived", sb.expected.size()));
    end

    $display("covered %0d pixel, %0d bin read, %0d restart and %0d unused-mode words",
             sb.words_by_mode[MODE_PIXEL], sb.words_by_mode[MODE_READ],
             sb.words_by_mode[MODE_RESTART], sb.words_by_mode[MODE_UNUSED]);
    $display("over %0d width settings; %0d result words compared, %0d mismatches",
             width_writes, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
